[design/bdel_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package bdel_pkg;

  // Fixed field widths of the two channels.
  localparam int CMD_W    = 3;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 7;

  // Defaults for the top-level parameters.
  localparam int DEPTH_DEF      = 64;
  localparam int DATA_WIDTH_DEF = 32;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_BACK  = 3'd0,
    CMD_PUSH_FRONT = 3'd1,
    CMD_POP_BACK   = 3'd2,
    CMD_POP_FRONT  = 3'd3,
    CMD_DUMP       = 3'd4,
    CMD_CLEAR      = 3'd5
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_DUMP = 1'b1
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic exec;        // an input transaction is taken this cycle
    logic dump_start;  // the taken transaction starts a dump of a non-empty list
    logic dump_emit;   // load the next dumped element into the output register
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;    // output register can take a new result this cycle
    logic empty;       // list holds no element
    logic dump_last;   // element at the dump offset is the final one
  } dp_sts_t;

endpackage
`default_nettype wire

[design/bounded_double_ended_list_unit.sv]
`timescale 1ns / 1ps
// A single result is loaded into the output register in the cycle after its transaction is taken;
// the first element of a dump passes through the registered memory read before the output register.
// Throughput: push, pop, clear and no-op commands sustain one transaction per cycle while the output is not stalled.
// A dump of a non-empty list stalls the input until its final element is loaded into the output register.
// Reset (synchronous, rst_n low) empties the list and drops any pending result;
// the element memory itself is not cleared and needs no clearing pass.
`default_nettype none
module bounded_double_ended_list_unit
  import bdel_pkg::*;
#(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic        [CMD_W-1:0]    in_command,
  input  wire logic signed [VALUE_W-1:0]  in_value,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic             [STATUS_W-1:0] out_status,
  output logic signed      [VALUE_W-1:0]  out_element,
  output logic             [COUNT_W-1:0]  out_count,
  output logic                            out_last
);

  // The controller decides when an input transaction is taken and steps
  // through a dump one element at a time. Everything else, including the
  // circular buffer, the head pointer, the element count and the output
  // register, lives in the datapath.
  ctrl_cmd_t cmd;
  dp_sts_t   sts;

  // In the idle state the input is taken whenever the output register is
  // empty or is being drained in the same cycle, so single-result commands
  // flow at full rate. A dump of a non-empty list moves the controller to
  // its dump state, where the input stays stalled until the final element
  // has been loaded into the output register.
  bdel_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_command (in_command),
    .in_stall   (in_stall),
    .sts        (sts),
    .cmd        (cmd)
  );

  // The datapath keeps the elements in a single-port-write, registered-read
  // memory. Pushes at either end write one slot; pops only move the head
  // pointer or the count. During a dump the read address tracks the next
  // offset so that one element is ready every cycle the consumer accepts.
  bdel_dpath #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dpath (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_command  (in_command),
    .in_value    (in_value),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_status  (out_status),
    .out_element (out_element),
    .out_count   (out_count),
    .out_last    (out_last),
    .cmd         (cmd),
    .sts         (sts)
  );

endmodule
`default_nettype wire

[design/bdel_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
module bdel_ctrl
  import bdel_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  input  wire logic [CMD_W-1:0] in_command,
  output logic                  in_stall,
  input  dp_sts_t               sts,
  output ctrl_cmd_t             cmd
);

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    in_stall       = 1'b1;
    cmd.exec       = 1'b0;
    cmd.dump_start = 1'b0;
    cmd.dump_emit  = 1'b0;
    case (state_r)
      S_IDLE: begin
        // A new transaction is taken whenever the output register has room.
        in_stall = !sts.out_free;
        if (in_valid && sts.out_free) begin
          cmd.exec = 1'b1;
          if (cmd_t'(in_command) == CMD_DUMP && !sts.empty) begin
            cmd.dump_start = 1'b1;
            state_nxt      = S_DUMP;
          end
        end
      end
      S_DUMP: begin
        // One element leaves per cycle while the consumer keeps up.
        if (sts.out_free) begin
          cmd.dump_emit = 1'b1;
          if (sts.dump_last) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

[design/bdel_dpath.sv]
`timescale 1ns / 1ps
`default_nettype none
module bdel_dpath
  import bdel_pkg::*;
#(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic        [CMD_W-1:0]    in_command,
  input  wire logic signed [VALUE_W-1:0]  in_value,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic             [STATUS_W-1:0] out_status,
  output logic signed      [VALUE_W-1:0]  out_element,
  output logic             [COUNT_W-1:0]  out_count,
  output logic                            out_last,
  input  ctrl_cmd_t                       cmd,
  output dp_sts_t                         sts
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int SUM_W = PTR_W + 1;

  // Circular storage: slot of the element at a given offset from the head.
  function automatic logic [PTR_W-1:0] wrap_slot(input logic [SUM_W-1:0] sum);
    logic [SUM_W-1:0] adj;
    begin
      adj = (sum >= SUM_W'(DEPTH)) ? (sum - SUM_W'(DEPTH)) : sum;
      wrap_slot = adj[PTR_W-1:0];
    end
  endfunction

  logic [DATA_WIDTH-1:0] entries [DEPTH];
  logic [DATA_WIDTH-1:0] rd_data_r;
  logic [PTR_W-1:0]      rd_addr;
  logic                  wr_en;
  logic [PTR_W-1:0]      wr_addr;
  logic [DATA_WIDTH-1:0] wr_data;

  logic [PTR_W-1:0] head_r, head_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_W-1:0] off_r, off_nxt;
  logic [CNT_W-1:0] off_inc;

  logic                      out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0]       out_status_r, out_status_nxt;
  logic signed [VALUE_W-1:0] out_element_r, out_element_nxt;
  logic [COUNT_W-1:0]        out_count_r, out_count_nxt;
  logic                      out_last_r, out_last_nxt;

  logic        full;
  logic        empty;
  logic        load_single;
  status_t     op_status;
  logic [63:0] val_ext;
  logic signed [63:0] elem_ext;

  assign full     = (cnt_r == CNT_W'(DEPTH));
  assign empty    = (cnt_r == '0);
  assign off_inc  = CNT_W'(off_r + CNT_W'(1));
  assign val_ext  = 64'(unsigned'(in_value));
  assign wr_data  = val_ext[DATA_WIDTH-1:0];
  assign elem_ext = 64'(signed'(rd_data_r));

  assign sts.out_free  = !out_valid_r || !out_stall;
  assign sts.empty     = empty;
  assign sts.dump_last = (off_inc == cnt_r);

  assign load_single = cmd.exec && !cmd.dump_start;

  // List operation for a taken transaction.
  always_comb begin
    head_nxt  = head_r;
    cnt_nxt   = cnt_r;
    wr_en     = 1'b0;
    wr_addr   = head_r;
    op_status = ST_OK;
    if (cmd.exec) begin
      case (cmd_t'(in_command))
        CMD_PUSH_BACK: begin
          if (full) begin
            op_status = ST_FULL;
          end else begin
            wr_en   = 1'b1;
            wr_addr = wrap_slot(SUM_W'(head_r) + SUM_W'(cnt_r));
            cnt_nxt = CNT_W'(cnt_r + CNT_W'(1));
          end
        end
        CMD_PUSH_FRONT: begin
          if (full) begin
            op_status = ST_FULL;
          end else begin
            head_nxt = (head_r == '0) ? PTR_W'(DEPTH - 1) : PTR_W'(head_r - PTR_W'(1));
            wr_en    = 1'b1;
            wr_addr  = head_nxt;
            cnt_nxt  = CNT_W'(cnt_r + CNT_W'(1));
          end
        end
        CMD_POP_BACK: begin
          if (empty) begin
            op_status = ST_EMPTY;
          end else begin
            cnt_nxt = CNT_W'(cnt_r - CNT_W'(1));
          end
        end
        CMD_POP_FRONT: begin
          if (empty) begin
            op_status = ST_EMPTY;
          end else begin
            head_nxt = wrap_slot(SUM_W'(head_r) + SUM_W'(1));
            cnt_nxt  = CNT_W'(cnt_r - CNT_W'(1));
          end
        end
        CMD_DUMP: begin
          if (empty) begin
            op_status = ST_EMPTY;
          end
        end
        CMD_CLEAR: begin
          head_nxt = '0;
          cnt_nxt  = '0;
        end
        default: begin
        end
      endcase
    end
  end

  // The read port points at the slot of the next dump offset, so rd_data_r
  // is registered together with off_r and holds the element at that offset.
  always_comb begin
    off_nxt = off_r;
    if (cmd.dump_start) begin
      off_nxt = '0;
    end else if (cmd.dump_emit) begin
      off_nxt = off_inc;
    end
    rd_addr = wrap_slot(SUM_W'(head_r) + SUM_W'(off_nxt));
  end

  always_comb begin
    out_valid_nxt   = out_valid_r;
    out_status_nxt  = out_status_r;
    out_element_nxt = out_element_r;
    out_count_nxt   = out_count_r;
    out_last_nxt    = out_last_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (load_single) begin
      out_valid_nxt   = 1'b1;
      out_status_nxt  = op_status;
      out_element_nxt = '0;
      out_count_nxt   = COUNT_W'(cnt_nxt);
      out_last_nxt    = 1'b1;
    end else if (cmd.dump_emit) begin
      out_valid_nxt   = 1'b1;
      out_status_nxt  = ST_OK;
      out_element_nxt = elem_ext[VALUE_W-1:0];
      out_count_nxt   = COUNT_W'(cnt_r);
      out_last_nxt    = sts.dump_last;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      entries[wr_addr] <= wr_data;
    end
    rd_data_r <= entries[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      head_r      <= head_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    off_r         <= off_nxt;
    out_status_r  <= out_status_nxt;
    out_element_r <= out_element_nxt;
    out_count_r   <= out_count_nxt;
    out_last_r    <= out_last_nxt;
  end

  assign out_valid   = out_valid_r;
  assign out_status  = out_status_r;
  assign out_element = out_element_r;
  assign out_count   = out_count_r;
  assign out_last    = out_last_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(DEPTH))
    else $error("element count exceeds capacity");

  a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec && !full && (cmd_t'(in_command) == CMD_PUSH_BACK ||
                          cmd_t'(in_command) == CMD_PUSH_FRONT)
    |=> cnt_r == CNT_W'($past(cnt_r) + CNT_W'(1)))
    else $error("accepted push did not grow the list by one");

  a_emit_loads: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.dump_emit |=> out_valid_r && out_status_r == ST_OK)
    else $error("dump emission did not load an ok result");

  a_no_exec_in_dump: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.exec && cmd.dump_emit))
    else $error("new transaction taken while a dump is running");

endmodule
`default_nettype wire
